// File: sv/gtsa_pkg.sv
// Package for the gated tanh-sigmoid activation.
// Holds the tanh knot table and shared widths; no dependencies.
`default_nettype none
package gtsa_pkg;

   localparam int unsigned TANH_IN_W  = 19;
   localparam int unsigned TANH_OUT_W = 17;
   localparam logic [TANH_OUT_W-1:0] ONE_Q16 = 17'd65536;
   localparam logic [3:0] KNOT_LAST = 4'd13;

   function automatic logic [TANH_OUT_W-1:0] tanh_knot(input logic [3:0] idx);
      logic [TANH_OUT_W-1:0] k;
      case (idx)
         4'd0:    k = 17'd0;
         4'd1:    k = 17'd30285;
         4'd2:    k = 17'd49912;
         4'd3:    k = 17'd59320;
         4'd4:    k = 17'd63179;
         4'd5:    k = 17'd64659;
         4'd6:    k = 17'd65212;
         4'd7:    k = 17'd65417;
         4'd8:    k = 17'd65492;
         4'd9:    k = 17'd65520;
         4'd10:   k = 17'd65530;
         4'd11:   k = 17'd65534;
         4'd12:   k = 17'd65535;
         default: k = 17'd65536;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// File: sv/gated_tanh_sigmoid_activation_top.sv
// Gated tanh-sigmoid activation: h = 4*tanh(g/4)*sigmoid(g)*25*tanh(u/25).
// Accepts one transfer per cycle while the pipeline is not held by rsp_stall.
// Five register stages each with a valid bit; a stalled stage holds and
// empty stages still fill, so bubbles are squeezed out.
// Reset (synchronous) clears the valid bits only.
// Depends on gtsa_pkg and gtsa_tanh.
`default_nettype none
module gated_tanh_sigmoid_activation_top
   import gtsa_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_gate_value,
   input  wire logic signed [31:0] req_up_value,
   input  wire logic               req_vector_end_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [23:0]      rsp_activation_out,
   output logic                    rsp_vector_end_out
);

   localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int SHR = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
   localparam int HSH = 32 - FRAC_BITS;
   localparam longint LIM_RAW = longint'(100) << FRAC_BITS;
   localparam logic [40:0] LIM = (LIM_RAW > 8388607) ? 41'd8388607 : 41'(LIM_RAW);
   localparam logic [40:0] X_CAP = 41'd425984;
   localparam logic [40:0] U_CAP = 41'd10649600;
   localparam logic [24:0] RECIP25 = 25'd21474837;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   assign adv5 = !v5_ff || !rsp_stall;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_stall = !adv1;

   // stage 1: magnitude, format, clamp
   logic        gneg, uneg;
   logic [32:0] gabs, uabs;
   logic [40:0] gm, um, g4, g2;
   logic [18:0] x4_in, x2_in;
   logic [23:0] uc_in;
   logic [18:0] x4_ff, x2_ff;
   logic [23:0] uc_ff;
   logic        gneg1_ff, hneg1_ff, end1_ff;

   always_comb begin
      gneg  = req_gate_value[31];
      uneg  = req_up_value[31];
      gabs  = gneg ? 33'h1_0000_0000 - {1'b0, req_gate_value} : {1'b0, req_gate_value};
      uabs  = uneg ? 33'h1_0000_0000 - {1'b0, req_up_value} : {1'b0, req_up_value};
      gm    = (41'(gabs) << SHL) >> SHR;
      um    = (41'(uabs) << SHL) >> SHR;
      g4    = gm >> 2;
      g2    = gm >> 1;
      x4_in = (g4 > X_CAP) ? X_CAP[18:0] : g4[18:0];
      x2_in = (g2 > X_CAP) ? X_CAP[18:0] : g2[18:0];
      uc_in = (um > U_CAP) ? U_CAP[23:0] : um[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= req_valid;
      end
      if (adv1) begin
         x4_ff    <= x4_in;
         x2_ff    <= x2_in;
         uc_ff    <= uc_in;
         gneg1_ff <= gneg;
         hneg1_ff <= gneg ^ uneg;
         end1_ff  <= req_vector_end_in;
      end
   end

   // stage 2: gate tanh values, up divided by 25
   logic [16:0] t4_in, th_in;
   logic [48:0] qprod;
   logic [16:0] t4_ff, th_ff;
   logic [18:0] qu_ff;
   logic        gneg2_ff, hneg2_ff, end2_ff;

   gtsa_tanh u_tanh_g4 (.x(x4_ff), .y(t4_in));
   gtsa_tanh u_tanh_g2 (.x(x2_ff), .y(th_in));
   assign qprod = 49'(uc_ff) * 49'(RECIP25);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
      if (adv2) begin
         t4_ff    <= t4_in;
         th_ff    <= th_in;
         qu_ff    <= qprod[47:29];
         gneg2_ff <= gneg1_ff;
         hneg2_ff <= hneg1_ff;
         end2_ff  <= end1_ff;
      end
   end

   // stage 3: sigmoid, gate product, up tanh
   logic [17:0] sum;
   logic [16:0] sig;
   logic [33:0] aprod;
   logic [16:0] t25;
   logic [21:0] t25x_in;
   logic [18:0] amag_ff;
   logic [21:0] t25x_ff;
   logic        hneg3_ff, end3_ff;

   gtsa_tanh u_tanh_u (.x(qu_ff), .y(t25));

   always_comb begin
      sum     = gneg2_ff ? 18'(ONE_Q16) - 18'(th_ff) : 18'(ONE_Q16) + 18'(th_ff);
      sig     = sum[17:1];
      aprod   = 34'(t4_ff) * 34'(sig);
      t25x_in = (22'(t25) << 4) + (22'(t25) << 3) + 22'(t25);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv3) begin
         v3_ff <= v2_ff;
      end
      if (adv3) begin
         amag_ff  <= aprod[32:14];
         t25x_ff  <= t25x_in;
         hneg3_ff <= hneg2_ff;
         end3_ff  <= end2_ff;
      end
   end

   // stage 4: final product
   logic [40:0] hprod_ff;
   logic        hneg4_ff, end4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv4) begin
         v4_ff <= v3_ff;
      end
      if (adv4) begin
         hprod_ff <= 41'(amag_ff) * 41'(t25x_ff);
         hneg4_ff <= hneg3_ff;
         end4_ff  <= end3_ff;
      end
   end

   // stage 5: scale, saturate, apply sign
   logic [40:0] hmag;
   logic [23:0] hsat;
   logic [23:0] res_in;
   logic [23:0] res_ff;
   logic        end5_ff;

   always_comb begin
      hmag   = hprod_ff >> HSH;
      hsat   = (hmag > LIM) ? LIM[23:0] : hmag[23:0];
      res_in = hneg4_ff ? 24'd0 - hsat : hsat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv5) begin
         v5_ff <= v4_ff;
      end
      if (adv5) begin
         res_ff  <= res_in;
         end5_ff <= end4_ff;
      end
   end

   assign rsp_valid          = v5_ff;
   assign rsp_activation_out = signed'(res_ff);
   assign rsp_vector_end_out = end5_ff;

endmodule
`default_nettype wire

// File: sv/gtsa_tanh.sv
// Piecewise-linear tanh of an unsigned Q16 magnitude, knots every 0.5.
// Uses gtsa_pkg for the knot table.
`default_nettype none
module gtsa_tanh
   import gtsa_pkg::*;
(
   input  wire logic [TANH_IN_W-1:0]  x,
   output logic      [TANH_OUT_W-1:0] y
);

   logic [3:0]  idx;
   logic [14:0] frac;
   logic [16:0] t0;
   logic [16:0] t1;
   logic [14:0] diff;
   logic [29:0] prod;

   always_comb begin
      idx  = x[18:15];
      frac = x[14:0];
      t0   = tanh_knot(idx);
      t1   = tanh_knot(idx + 4'd1);
      diff = 15'(t1 - t0);
      prod = 30'(diff) * 30'(frac);
      if (idx >= KNOT_LAST) begin
         y = ONE_Q16;
      end else begin
         y = t0 + 17'(prod[29:15]);
      end
   end

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Testbench for gated_tanh_sigmoid_activation_top: drives gate/up pairs over the
// request channel and compares every response against an in-bench predictor.
// Depends on gtsa_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module testbench;
   import gtsa_pkg::*;

   localparam int FRAC = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_gate_value = '0;
   logic signed [31:0] req_up_value = '0;
   logic req_vector_end_in = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_activation_out;
   logic rsp_vector_end_out;

   typedef struct packed {
      logic [23:0] act;
      logic        vend;
   } act_result_type;

   act_result_type expected_acts[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;
   int  sink_wait = 0;

   gated_tanh_sigmoid_activation_top #(.FRAC_BITS(FRAC)) dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] knot_of(input int k);
      logic [63:0] tbl [0:13];
      tbl = '{64'd0, 64'd30285, 64'd49912, 64'd59320, 64'd63179, 64'd64659,
              64'd65212, 64'd65417, 64'd65492, 64'd65520, 64'd65530, 64'd65534,
              64'd65535, 64'd65536};
      return tbl[k];
   endfunction

   function automatic logic [63:0] tanh_q16(input logic [63:0] x);
      logic [63:0] idx;
      logic [63:0] t0;
      logic [63:0] t1;
      idx = x >> 15;
      if (idx >= 13) return 64'd65536;
      t0 = knot_of(int'(idx));
      t1 = knot_of(int'(idx) + 1);
      return t0 + (((t1 - t0) * (x & 64'h7FFF)) >> 15);
   endfunction

   function automatic logic [63:0] q16_mag(input logic [31:0] raw, output bit neg);
      logic [63:0] m;
      neg = raw[31];
      m = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
      if (FRAC > 16) m = m >> (FRAC - 16);
      else m = m << (16 - FRAC);
      return m;
   endfunction

   function automatic act_result_type predict_activation(input logic [31:0] g,
                                                          input logic [31:0] u,
                                                          input logic vend);
      bit gneg;
      bit uneg;
      logic [63:0] gm;
      logic [63:0] um;
      logic [63:0] th;
      logic [63:0] sig;
      logic [63:0] amag;
      logic [63:0] hmag;
      logic [63:0] lim;
      act_result_type r;
      gm = q16_mag(g, gneg);
      um = q16_mag(u, uneg);
      th = tanh_q16(gm >> 1);
      sig = gneg ? ((64'd65536 - th) >> 1) : ((64'd65536 + th) >> 1);
      amag = (64'd4 * tanh_q16(gm >> 2) * sig) >> 16;
      hmag = (amag * 64'd25 * tanh_q16(um / 25)) >> (32 - FRAC);
      lim = 64'd100 << FRAC;
      if (lim > 64'd8388607) lim = 64'd8388607;
      if (hmag > lim) hmag = lim;
      r.act = (gneg != uneg) ? 24'(64'd0 - hmag) : hmag[23:0];
      r.vend = vend;
      return r;
   endfunction

   task automatic send_pair(input logic [31:0] g, input logic [31:0] u, input logic vend);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_gate_value <= g;
      req_up_value <= u;
      req_vector_end_in <= vend;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_acts.push_back(predict_activation(g, u, vend));
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_q(input int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 1200000)) - 600000);
         default: return 32'($signed($urandom_range(0, 16000000)) - 8000000);
      endcase
   endfunction

   task automatic test_extremes();
      logic [31:0] vals [8];
      vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1,
               32'h0006_8000, 32'hFFF9_8000, 32'h0019_0000};
      foreach (vals[i]) send_pair(vals[i], vals[(i + 3) % 8], i[0]);
   endtask

   task automatic test_saturation();
      send_pair(32'h0040_0000, 32'h0400_0000, 1'b1);
      send_pair(32'h0040_0000, 32'hFC00_0000, 1'b0);
      send_pair(32'hFFC0_0000, 32'h0400_0000, 1'b1);
      send_pair(32'hFFC0_0000, 32'hFC00_0000, 1'b0);
   endtask

   task automatic test_knots();
      for (int k = 0; k < 8; k++)
         send_pair(32'(k * 32768 * 4), 32'(k * 32768 * 25), k[0]);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++)
         send_pair(rand_q($urandom_range(0, 2)), rand_q($urandom_range(0, 2)),
                   1'($urandom_range(0, 1)));
   endtask

   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 1'b0;
         sink_wait = 0;
      end else if (sink_wait > 0) begin
         sink_wait = sink_wait - 1;
         if (sink_wait == 0) rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         sink_wait = $urandom_range(1, 13);
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      act_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_acts.size() == 0) begin
            $display("%0t: unexpected transfer act=%h vend=%b", $time,
                     rsp_activation_out, rsp_vector_end_out);
            errors++;
         end else begin
            e = expected_acts.pop_front();
            if (e.act !== rsp_activation_out)
               begin
                  $display("%0t: activation expected %h actual %h", $time, e.act,
                           rsp_activation_out);
                  errors++;
               end
            if (e.vend !== rsp_vector_end_out) begin
               $display("%0t: vector end expected %b actual %b", $time, e.vend,
                        rsp_vector_end_out);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_saturation();
      test_knots();
      test_random(1600);
      quiet = 1'b1;
      test_random(280);
      req_valid <= 1'b0;
      while (expected_acts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
